@@ src/css_pkg.sv @@
// Shared constants, types and filter functions for the chroma subsampler.
`timescale 1ns / 1ps
package css_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Register indexes on the configuration port
  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [2:0]  MODE_RST   = 3'd0;
  localparam logic [9:0]  WIDTH_RST  = 10'd320;
  localparam logic [10:0] HEIGHT_RST = 11'd240;

  // Mode codes
  localparam logic [2:0] MODE_444      = 3'd0;
  localparam logic [2:0] MODE_422      = 3'd1;
  localparam logic [2:0] MODE_420_JPEG = 3'd2;
  localparam logic [2:0] MODE_420_MPEG = 3'd3;
  localparam logic [2:0] MODE_420_COS  = 3'd4;

  // Filter kinds
  localparam logic [1:0] KIND_BOX   = 2'd0;
  localparam logic [1:0] KIND_121   = 2'd1;
  localparam logic [1:0] KIND_RIGHT = 2'd2;
  localparam logic [1:0] KIND_COS   = 2'd3;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = 3;

  typedef struct packed {
    logic       eof;
    logic       lor;
    logic [7:0] v;
    logic [7:0] u;
  } css_result_t;

  // One channel of the filter; weights and shifts per kind
  function automatic logic [7:0] kern8(input logic [1:0] kind,
                                       input logic [7:0] t0, input logic [7:0] t1,
                                       input logic [7:0] t2, input logic [7:0] m0,
                                       input logic [7:0] m1, input logic [7:0] m2,
                                       input logic [7:0] c0, input logic [7:0] c1,
                                       input logic [7:0] c2);
    logic [9:0]  wt;
    logic [9:0]  wm;
    logic [9:0]  wc;
    logic [11:0] s;
    logic [7:0]  res;
    wt = {2'b0, t0} + {1'b0, t1, 1'b0} + {2'b0, t2};
    wm = {2'b0, m0} + {1'b0, m1, 1'b0} + {2'b0, m2};
    wc = {2'b0, c0} + {1'b0, c1, 1'b0} + {2'b0, c2};
    case (kind)
      KIND_BOX: begin
        s   = {4'b0, m1} + {4'b0, m2} + {4'b0, c1} + {4'b0, c2};
        res = s[9:2];
      end
      KIND_121: begin
        s   = {2'b0, wm} + {2'b0, wc};
        res = s[10:3];
      end
      KIND_RIGHT: begin
        s   = {4'b0, m1} + {3'b0, m2, 1'b0} + {4'b0, m2}
            + {4'b0, c1} + {3'b0, c2, 1'b0} + {4'b0, c2};
        res = s[10:3];
      end
      default: begin
        s   = {2'b0, wt} + {1'b0, wm, 1'b0} + {2'b0, wc};
        res = s[11:4];
      end
    endcase
    return res;
  endfunction

  // Pair form: V in the high byte, U in the low byte
  function automatic logic [15:0] kern16(input logic [1:0] kind,
                                         input logic [15:0] t0, input logic [15:0] t1,
                                         input logic [15:0] t2, input logic [15:0] m0,
                                         input logic [15:0] m1, input logic [15:0] m2,
                                         input logic [15:0] c0, input logic [15:0] c1,
                                         input logic [15:0] c2);
    return {kern8(kind, t0[15:8], t1[15:8], t2[15:8], m0[15:8], m1[15:8], m2[15:8],
                  c0[15:8], c1[15:8], c2[15:8]),
            kern8(kind, t0[7:0], t1[7:0], t2[7:0], m0[7:0], m1[7:0], m2[7:0],
                  c0[7:0], c1[7:0], c2[7:0])};
  endfunction

endpackage

@@ src/chroma_subsampler_unit.sv @@
// Top level of the chroma subsampler: 4:4:4 chroma stream to 4:2:2 / 4:2:0, or passed through.
//
// Input beats carry one (U,V) pair in raster order on in_* (valid/ready).
// Result beats leave on out_*; end_of_frame marks the final result of the
// frame, last_of_run the last result caused by one input beat.
// Configuration: cfg_index 0 = mode, 1 = frame width, 2 = frame height;
// write only while the block is idle. cfg_ready is always high.
// Throughput: one input beat per cycle while in_ready is high. Filtered
// modes emit on odd columns only; 4:2:2 emits two results per odd column
// of the last row, which the output queue absorbs since the even column
// before emits none. Input accept to out_valid: line-store read alongside
// the stage 1 registers, then filter into the 8-entry output queue.
// Two line stores (row above, row two above) hold column pairs, one RAM
// entry per pair: each odd column reads its pair, filters, and writes the
// pair back in the following cycle, so read and write-back never collide.
// Reset clears counters, pipeline and queue; line stores need no clearing.
// When the receiver stalls, the queue fills and in_ready drops; no beat is
// lost or repeated.
`timescale 1ns / 1ps
module chroma_subsampler_unit
  import css_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_u_sample,
  input  logic [7:0]  in_v_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_u_result,
  output logic [7:0]  out_v_result,
  output logic        out_end_of_frame,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int AW = CW - 1;
  localparam logic [12:0] MAXW_EVEN = 13'(MAX_WIDTH - MAX_WIDTH % 2);
  localparam logic [12:0] MAXH_EVEN = 13'(MAX_HEIGHT - MAX_HEIGHT % 2);

  // Configuration registers
  logic [2:0]  mode_r;
  logic [9:0]  fw_r;
  logic [10:0] fh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RST;
      fw_r   <= WIDTH_RST;
      fh_r   <= HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:   mode_r <= cfg_data[2:0];
        CFG_WIDTH:  fw_r   <= cfg_data[9:0];
        CFG_HEIGHT: fh_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Effective frame size, even and saturated
  logic [12:0]   w_eff, h_eff, w_raw, h_raw;
  logic [CW-1:0] wlast;
  logic [RW-1:0] hlast;

  always_comb begin
    w_raw = {3'b0, fw_r[9:1], 1'b0};
    h_raw = {2'b0, fh_r[10:1], 1'b0};
    w_eff = (w_raw < 13'd2) ? 13'd2 : (w_raw > MAXW_EVEN) ? MAXW_EVEN : w_raw;
    h_eff = (h_raw < 13'd2) ? 13'd2 : (h_raw > MAXH_EVEN) ? MAXH_EVEN : h_raw;
    wlast = CW'(w_eff - 13'd1);
    hlast = RW'(h_eff - 13'd1);
  end

  // Stage 0: counters, window registers, mode decode
  logic [CW-1:0] col_r, col_nxt, c;
  logic [RW-1:0] row_r, row_nxt, r;
  logic [15:0]   rec0_r, rec1_r, p;
  logic          accept;
  logic          pass, odd, last_px, last_row;
  logic [1:0]    n0;
  logic [1:0]    kind;

  assign accept = in_valid && in_ready;
  assign p      = {in_v_sample, in_u_sample};

  always_comb begin
    c        = (col_r > wlast) ? wlast : col_r;
    r        = (row_r > hlast) ? hlast : row_r;
    last_row = (r == hlast);
    last_px  = last_row && (c == wlast);
    pass     = (mode_r == MODE_444) || (mode_r > MODE_420_COS);
    odd      = c[0];
    case (mode_r)
      MODE_420_JPEG: kind = KIND_BOX;
      MODE_420_MPEG: kind = KIND_121;
      MODE_420_COS:  kind = KIND_COS;
      default:       kind = (c == wlast && c != CW'(1)) ? KIND_RIGHT : KIND_121;
    endcase
    // results caused by this beat
    if (pass) begin
      n0 = 2'd1;
    end else if (!odd) begin
      n0 = 2'd0;
    end else if (mode_r == MODE_422) begin
      n0 = last_row ? 2'd2 : (r != '0) ? 2'd1 : 2'd0;
    end else begin
      n0 = r[0] ? 2'd1 : 2'd0;
    end
    if (c == wlast) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : RW'(r + RW'(1));
    end else begin
      col_nxt = CW'(c + CW'(1));
      row_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      rec0_r <= '0;
      rec1_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      rec0_r <= p;
      rec1_r <= rec0_r;
    end
  end

  // Stage 1 registers
  logic          s1_v_r;
  logic [1:0]    s1_n_r;
  logic          s1_pass_r, s1_odd_r, s1_cl_r, s1_top_r, s1_last_r;
  logic [1:0]    s1_kind_r;
  logic [15:0]   s1_c0_r, s1_c1_r, s1_c2_r;
  logic [AW-1:0] s1_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s1_n_r <= 2'd0;
    end else begin
      s1_v_r <= accept;
      s1_n_r <= accept ? n0 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pass_r <= pass;
      s1_odd_r  <= odd;
      s1_cl_r   <= (c >= CW'(2));
      s1_top_r  <= (r == RW'(1));
      s1_last_r <= last_px;
      s1_kind_r <= kind;
      s1_c0_r   <= (c >= CW'(2)) ? rec1_r : rec0_r;
      s1_c1_r   <= rec0_r;
      s1_c2_r   <= p;
      s1_addr_r <= c[CW-1:1];
    end
  end

  // Line stores: one entry per column pair, {odd column, even column}
  logic [31:0] mid_rd, up_rd;
  logic        st_we;

  assign st_we = s1_v_r && s1_odd_r;

  css_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_mid_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_addr_r),
    .wdata ({s1_c2_r, s1_c1_r}),
    .raddr (c[CW-1:1]),
    .rdata (mid_rd)
  );

  css_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_up_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (s1_addr_r),
    .wdata (mid_rd),
    .raddr (c[CW-1:1]),
    .rdata (up_rd)
  );

  // Hold the odd column of the previous pair of both rows for the left tap
  logic [15:0] pm_odd_r, pu_odd_r;

  always_ff @(posedge clk) begin
    if (st_we) begin
      pm_odd_r <= mid_rd[31:16];
      pu_odd_r <= up_rd[31:16];
    end
  end

  // Filter
  logic [15:0] m0, m1, m2, t0, t1, t2, res_a, res_b;

  always_comb begin
    m0 = s1_cl_r ? pm_odd_r : mid_rd[15:0];
    m1 = mid_rd[15:0];
    m2 = mid_rd[31:16];
    if (s1_top_r) begin
      t0 = m0;
      t1 = m1;
      t2 = m2;
    end else begin
      t0 = s1_cl_r ? pu_odd_r : up_rd[15:0];
      t1 = up_rd[15:0];
      t2 = up_rd[31:16];
    end
    res_a = kern16(s1_kind_r, t0, t1, t2, m0, m1, m2, s1_c0_r, s1_c1_r, s1_c2_r);
    res_b = kern16(s1_kind_r, t0, t1, t2, s1_c0_r, s1_c1_r, s1_c2_r,
                   s1_c0_r, s1_c1_r, s1_c2_r);
  end

  // Output queue
  css_result_t        fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  css_result_t        slot0, slot1;
  logic [15:0]        pair0;
  logic               pop;
  logic [3:0]         need;

  always_comb begin
    pair0 = s1_pass_r ? s1_c2_r : res_a;
    slot0 = '{eof: s1_last_r && (s1_n_r == 2'd1), lor: (s1_n_r == 2'd1),
              v: pair0[15:8], u: pair0[7:0]};
    slot1 = '{eof: s1_last_r, lor: 1'b1, v: res_b[15:8], u: res_b[7:0]};
  end

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign need      = 4'(cnt_r) + 4'(s1_n_r) + 4'd2;
  assign in_ready  = (need <= 4'(FIFO_DEPTH));

  assign out_u_result     = fifo_r[rp_r].u;
  assign out_v_result     = fifo_r[rp_r].v;
  assign out_end_of_frame = fifo_r[rp_r].eof;
  assign out_last_of_run  = fifo_r[rp_r].lor;

  always_ff @(posedge clk) begin
    if (s1_n_r != 2'd0) begin
      fifo_r[wp_r] <= slot0;
    end
    if (s1_n_r == 2'd2) begin
      fifo_r[FIFO_AW'(wp_r + FIFO_AW'(1))] <= slot1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= FIFO_AW'(wp_r + FIFO_AW'(s1_n_r));
      rp_r  <= FIFO_AW'(rp_r + FIFO_AW'(pop));
      cnt_r <= (FIFO_AW + 1)'(cnt_r + (FIFO_AW + 1)'(s1_n_r) - (FIFO_AW + 1)'(pop));
    end
  end

endmodule

@@ src/css_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module css_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
